>>> rtl/pba_pkg.sv
package pba_pkg;
	localparam int PAGE_COUNT = 32768;
	localparam int WORD_BITS = 8;
	localparam int WORD_COUNT = PAGE_COUNT / WORD_BITS;
	localparam int WADDR_W = $clog2(WORD_COUNT);
	localparam int PAGE_W = $clog2(PAGE_COUNT);
	localparam logic [32:0] MEM_LIMIT = 33'(PAGE_COUNT) << 12;
	localparam logic [31:0] LOW_MEM_END = 32'h0010_0000;
	localparam logic [31:0] KERNEL_RESET = 32'h0010_0000;

	typedef enum logic [2:0] {
		KIND_FILL = 3'd0,
		KIND_REGION = 3'd1,
		KIND_RESERVE = 3'd2,
		KIND_FINISH = 3'd3,
		KIND_ALLOC = 3'd4,
		KIND_FREE = 3'd5
	} kind_t;

	typedef enum logic [0:0] {
		CFG_KSTART = 1'b0,
		CFG_KEND = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MOD,
		ST_SPAN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_RUN,
		TOP_RUN2,
		TOP_OUT
	} top_state_t;

	typedef enum logic [1:0] {
		OP_FILL,
		OP_MARK,
		OP_ALLOC,
		OP_FREE
	} op_t;

	function automatic logic [32:0] align_up(input logic [31:0] a);
		logic [31:0] r;
		r = (a[11:0] != 12'd0) ? {a[31:12] + 20'd1, 12'd0} : a;
		return {1'b0, r};
	endfunction

	function automatic logic [32:0] align_down(input logic [31:0] a);
		return {1'b0, a[31:12], 12'd0};
	endfunction
endpackage

>>> rtl/pba_ram.sv
module pba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/pba_engine.sv
module pba_engine (
	input logic clk,
	input logic arst_n,
	input logic start,
	input pba_pkg::op_t op,
	input logic [32:0] span_lo,
	input logic [32:0] span_hi,
	input logic mark_val,
	input logic [pba_pkg::PAGE_W-1:0] free_page,
	output logic busy,
	output logic done,
	output logic [31:0] res_address,
	output logic res_ok
);
	import pba_pkg::*;

	state_t state_q, state_d;
	op_t op_q;
	logic [WADDR_W:0] widx_q;
	logic [32:0] pos_q;
	logic [32:0] hi_q;
	logic val_q;
	logic [PAGE_W-1:0] page_q;
	logic [31:0] addr_q;
	logic ok_q;

	logic [WADDR_W-1:0] raddr;
	logic we;
	logic [WADDR_W-1:0] waddr;
	logic [7:0] u_wdata, r_wdata, u_rdata, r_rdata;

	pba_ram #(.WIDTH(8), .DEPTH(WORD_COUNT)) u_used (
		.clk(clk), .we(we), .waddr(waddr), .wdata(u_wdata),
		.raddr(raddr), .rdata(u_rdata)
	);
	pba_ram #(.WIDTH(8), .DEPTH(WORD_COUNT)) u_rsv (
		.clk(clk), .we(we), .waddr(waddr), .wdata(r_wdata),
		.raddr(raddr), .rdata(r_rdata)
	);

	logic span_go;
	logic [PAGE_W-1:0] cur_page;
	logic [2:0] bitpos;
	logic [7:0] bmask;
	logic [7:0] free_bits;
	logic [2:0] first_free;
	logic any_free;

	assign span_go = (pos_q < hi_q) && (pos_q < MEM_LIMIT);
	assign cur_page = (op_q == OP_FREE) ? page_q : pos_q[12 +: PAGE_W];
	assign bitpos = cur_page[2:0];
	assign bmask = 8'(1) << bitpos;
	assign free_bits = ~u_rdata;
	assign any_free = |free_bits;

	always_comb begin
		first_free = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (free_bits[i]) begin
				first_free = 3'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		raddr = cur_page[PAGE_W-1:3];
		we = 1'b0;
		waddr = cur_page[PAGE_W-1:3];
		u_wdata = u_rdata;
		r_wdata = r_rdata;
		if (op_q == OP_ALLOC) begin
			raddr = widx_q[WADDR_W-1:0];
			waddr = widx_q[WADDR_W-1:0];
		end
		if (op_q == OP_FILL) begin
			waddr = widx_q[WADDR_W-1:0];
			u_wdata = 8'hFF;
			r_wdata = 8'hFF;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SPAN;
				end
			end
			ST_SPAN: begin
				unique case (op_q)
					OP_FILL: begin
						we = 1'b1;
						if (widx_q == (WADDR_W+1)'(WORD_COUNT - 1)) begin
							state_d = ST_DONE;
						end
					end
					OP_MARK: state_d = span_go ? ST_READ : ST_DONE;
					OP_ALLOC: state_d = (widx_q == (WADDR_W+1)'(WORD_COUNT)) ?
						ST_DONE : ST_READ;
					OP_FREE: state_d = ST_READ;
					default: state_d = ST_DONE;
				endcase
			end
			ST_READ: state_d = ST_MOD;
			ST_MOD: begin
				unique case (op_q)
					OP_MARK: begin
						we = 1'b1;
						u_wdata = val_q ? (u_rdata | bmask) : (u_rdata & ~bmask);
						r_wdata = val_q ? (r_rdata | bmask) : (r_rdata & ~bmask);
						state_d = ST_SPAN;
					end
					OP_ALLOC: begin
						if (any_free) begin
							we = 1'b1;
							u_wdata = u_rdata | (8'(1) << first_free);
							state_d = ST_DONE;
						end else begin
							state_d = ST_SPAN;
						end
					end
					OP_FREE: begin
						if (u_rdata[bitpos] && !r_rdata[bitpos]) begin
							we = 1'b1;
							u_wdata = u_rdata & ~bmask;
						end
						state_d = ST_DONE;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// reset starts a fill pass so both maps come up all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SPAN;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_FILL;
			widx_q <= '0;
			pos_q <= '0;
			hi_q <= '0;
			val_q <= 1'b0;
			page_q <= '0;
			addr_q <= '0;
			ok_q <= 1'b0;
		end else if (state_q == ST_IDLE && start) begin
			op_q <= op;
			widx_q <= '0;
			pos_q <= span_lo;
			hi_q <= span_hi;
			val_q <= mark_val;
			page_q <= free_page;
			addr_q <= '0;
			ok_q <= 1'b0;
		end else begin
			if (state_q == ST_SPAN && op_q == OP_FILL) begin
				widx_q <= widx_q + 1'b1;
			end
			if (state_q == ST_MOD) begin
				unique case (op_q)
					OP_MARK: pos_q <= pos_q + 33'h1000;
					OP_ALLOC: begin
						if (any_free) begin
							addr_q <= 32'({widx_q[WADDR_W-1:0], first_free}) << 12;
							ok_q <= 1'b1;
						end else begin
							widx_q <= widx_q + 1'b1;
						end
					end
					OP_FREE: ok_q <= u_rdata[bitpos] && !r_rdata[bitpos];
					default: ok_q <= 1'b0;
				endcase
			end
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign res_address = addr_q;
	assign res_ok = ok_q;
endmodule

>>> rtl/page_bitmap_allocator.sv
// Page-frame allocator holding used and reserved bitmaps in two 8-bit-wide
// synchronous RAMs (one byte per eight pages). One operation is in flight at a
// time. Fill sweeps every RAM word. Region and reserve walk one page at a
// time (read, modify, write back); finish runs two such walks back to back.
// Alloc scans the used bitmap one byte at a time up to the first free page.
// After reset an internal fill pass sets both bitmaps to all ones; in_ready
// stays low until it ends. Config writes are taken only when idle.
module page_bitmap_allocator (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] kind,
	input logic [31:0] region_base,
	input logic [31:0] region_length,
	input logic [31:0] region_type,
	input logic [31:0] range_start,
	input logic [31:0] range_end,
	input logic [31:0] free_address,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] page_address,
	output logic success,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [31:0] cfg_data
);
	import pba_pkg::*;

	top_state_t tstate_q, tstate_d;
	logic [31:0] kstart_q, kend_q;
	logic [2:0] kind_q;
	logic [31:0] base_q, len_q, type_q, rs_q, re_q, fa_q;

	logic eng_start, eng_busy, eng_done, eng_ok;
	logic [31:0] eng_addr;
	op_t eng_op;
	logic [32:0] lo, hi;
	logic mval;
	logic in_acc;
	logic free_pre;

	assign in_acc = in_valid && in_ready;
	assign in_ready = (tstate_q == TOP_IDLE) && !eng_busy;
	assign cfg_ready = (tstate_q == TOP_IDLE);

	assign free_pre = (fa_q[11:0] == 12'd0) && (fa_q >= LOW_MEM_END) &&
		({1'b0, fa_q} < MEM_LIMIT);

	always_comb begin
		eng_op = OP_MARK;
		lo = '0;
		hi = '0;
		mval = 1'b1;
		unique case (kind_q)
			KIND_FILL: eng_op = OP_FILL;
			KIND_REGION: begin
				mval = 1'b0;
				if (type_q == 32'd1) begin
					lo = align_up(base_q);
					hi = align_down(base_q + len_q);
				end
			end
			KIND_RESERVE: begin
				lo = align_down(rs_q);
				hi = align_up(re_q);
			end
			KIND_FINISH: begin
				if (tstate_q == TOP_RUN) begin
					lo = '0;
					hi = {1'b0, LOW_MEM_END};
				end else begin
					lo = align_down(kstart_q);
					hi = align_up(kend_q);
				end
			end
			KIND_ALLOC: eng_op = OP_ALLOC;
			KIND_FREE: eng_op = free_pre ? OP_FREE : OP_MARK;
			default: eng_op = OP_MARK;
		endcase
	end

	logic started_q;
	assign eng_start = (tstate_q == TOP_RUN || tstate_q == TOP_RUN2) && !started_q;

	pba_engine u_eng (
		.clk(clk), .arst_n(arst_n), .start(eng_start), .op(eng_op),
		.span_lo(lo), .span_hi(hi), .mark_val(mval),
		.free_page(fa_q[12 +: PAGE_W]),
		.busy(eng_busy), .done(eng_done), .res_address(eng_addr), .res_ok(eng_ok)
	);

	always_comb begin
		tstate_d = tstate_q;
		unique case (tstate_q)
			TOP_IDLE: if (in_acc) tstate_d = TOP_RUN;
			TOP_RUN: if (eng_done) tstate_d = (kind_q == KIND_FINISH) ? TOP_RUN2 : TOP_OUT;
			TOP_RUN2: if (eng_done) tstate_d = TOP_OUT;
			TOP_OUT: if (out_ready) tstate_d = TOP_IDLE;
			default: tstate_d = TOP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tstate_q <= TOP_IDLE;
			started_q <= 1'b0;
			kstart_q <= KERNEL_RESET;
			kend_q <= KERNEL_RESET;
		end else begin
			tstate_q <= tstate_d;
			if (eng_start) begin
				started_q <= 1'b1;
			end else if (eng_done) begin
				started_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_KSTART: kstart_q <= cfg_data;
					CFG_KEND: kend_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= kind;
			base_q <= region_base;
			len_q <= region_length;
			type_q <= region_type;
			rs_q <= range_start;
			re_q <= range_end;
			fa_q <= free_address;
		end
		if (tstate_q == TOP_RUN && eng_done) begin
			page_address <= (kind_q == KIND_ALLOC) ? eng_addr : 32'd0;
			success <= (kind_q == KIND_ALLOC || kind_q == KIND_FREE) ? eng_ok : 1'b0;
		end
	end

	assign out_valid = (tstate_q == TOP_OUT);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		eng_busy |-> !in_ready) else $error("input taken while engine busy");
	a_out_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind_q != KIND_ALLOC) |-> (page_address == 32'd0))
		else $error("address on non-alloc result");
	a_done_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		eng_done |=> !eng_done) else $error("engine done held");
endmodule

>>> bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pba_pkg::*;

	localparam logic [2:0] KIND_SPARE6 = 3'd6;
	localparam logic [2:0] KIND_SPARE7 = 3'd7;
	localparam logic [31:0] PAGE_BYTES = 32'h0000_1000;
	localparam int IDLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 1300;

	typedef struct {
		logic [2:0] kind;
		logic [31:0] base;
		logic [31:0] len;
		logic [31:0] rtype;
		logic [31:0] rstart;
		logic [31:0] rend;
		logic [31:0] faddr;
	} page_op_t;

	typedef struct {
		logic [2:0] kind;
		logic [31:0] addr;
		logic ok;
	} grant_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid, in_ready;
	logic [2:0] kind;
	logic [31:0] region_base, region_length, region_type;
	logic [31:0] range_start, range_end, free_address;
	logic out_valid, out_ready;
	logic [31:0] page_address;
	logic success;
	logic cfg_valid, cfg_ready;
	logic [0:0] cfg_index;
	logic [31:0] cfg_data;

	page_bitmap_allocator dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow allocator state
	bit used_bits[PAGE_COUNT];
	bit rsv_bits[PAGE_COUNT];
	logic [31:0] kern_start = KERNEL_RESET;
	logic [31:0] kern_end = KERNEL_RESET;

	page_op_t op_queue[$];
	grant_t grants_due[$];
	logic [31:0] granted_pages[$];
	int errors = 0;
	int idle_cycles = 0;
	bit in_burst = 1'b0;
	bit out_burst = 1'b0;

	function automatic logic [32:0] page_up(logic [31:0] a);
		logic [31:0] r;
		r = (a[11:0] != 12'd0) ? {a[31:12] + 20'd1, 12'd0} : a;
		return {1'b0, r};
	endfunction

	function automatic logic [32:0] page_down(logic [31:0] a);
		return {1'b0, a[31:12], 12'd0};
	endfunction

	function automatic void mark_pages(logic [32:0] s, logic [32:0] e, bit v);
		logic [32:0] a;
		int pg;
		for (a = s; a < e && a < MEM_LIMIT; a = a + 33'h1000) begin
			pg = a[31:12];
			used_bits[pg] = v;
			rsv_bits[pg] = v;
		end
	endfunction

	function automatic void fill_all();
		for (int p = 0; p < PAGE_COUNT; p++) begin
			used_bits[p] = 1'b1;
			rsv_bits[p] = 1'b1;
		end
	endfunction

	function automatic int count_free();
		int n;
		n = 0;
		for (int p = 0; p < PAGE_COUNT; p++)
			if (!used_bits[p])
				n++;
		return n;
	endfunction

	function automatic grant_t allocator_step(page_op_t op);
		grant_t g;
		int pg;
		g.kind = op.kind;
		g.addr = 32'd0;
		g.ok = 1'b0;
		case (op.kind)
			KIND_FILL: fill_all();
			KIND_REGION: begin
				if (op.rtype == 32'd1)
					mark_pages(page_up(op.base), page_down(op.base + op.len), 1'b0);
			end
			KIND_RESERVE: mark_pages(page_down(op.rstart), page_up(op.rend), 1'b1);
			KIND_FINISH: begin
				mark_pages(33'd0, {1'b0, LOW_MEM_END}, 1'b1);
				mark_pages(page_down(kern_start), page_up(kern_end), 1'b1);
			end
			KIND_ALLOC: begin
				for (int p = 0; p < PAGE_COUNT; p++) begin
					if (!used_bits[p]) begin
						used_bits[p] = 1'b1;
						g.addr = 32'(p) << 12;
						g.ok = 1'b1;
						break;
					end
				end
			end
			KIND_FREE: begin
				pg = op.faddr[31:12];
				if (op.faddr[11:0] == 12'd0 && op.faddr >= LOW_MEM_END &&
						{1'b0, op.faddr} < MEM_LIMIT && used_bits[pg] && !rsv_bits[pg]) begin
					used_bits[pg] = 1'b0;
					g.ok = 1'b1;
				end
			end
			default: ;
		endcase
		return g;
	endfunction

	// driver
	page_op_t cur_op;
	int in_hold = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= 3'd0;
			region_base <= 32'd0;
			region_length <= 32'd0;
			region_type <= 32'd0;
			range_start <= 32'd0;
			range_end <= 32'd0;
			free_address <= 32'd0;
			in_hold = 0;
		end else begin
			if (in_valid && in_ready) begin
				grants_due.push_back(allocator_step(cur_op));
				if ($urandom_range(0, 60) == 0)
					in_burst = !in_burst;
				in_hold = in_burst ? 0 : $urandom_range(0, 10);
			end
			if (in_valid && !in_ready) begin
			end else if (in_hold > 0) begin
				in_hold--;
				in_valid <= 1'b0;
			end else if (op_queue.size() > 0) begin
				cur_op = op_queue.pop_front();
				kind <= cur_op.kind;
				region_base <= cur_op.base;
				region_length <= cur_op.len;
				region_type <= cur_op.rtype;
				range_start <= cur_op.rstart;
				range_end <= cur_op.rend;
				free_address <= cur_op.faddr;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	int out_hold = 0;
	always @(posedge clk or negedge arst_n) begin
		grant_t g;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_hold = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (grants_due.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected, got addr %h ok %b",
						$time, page_address, success);
				end else begin
					g = grants_due.pop_front();
					if (page_address !== g.addr) begin
						errors++;
						$display("%0t: page_address expected %h got %h", $time, g.addr,
							page_address);
					end
					if (success !== g.ok) begin
						errors++;
						$display("%0t: success expected %b got %b", $time, g.ok, success);
					end
					if (g.kind == KIND_ALLOC && g.ok && g.addr >= LOW_MEM_END)
						granted_pages.push_back(g.addr);
				end
				if ($urandom_range(0, 60) == 0)
					out_burst = !out_burst;
				out_hold = out_burst ? 0 : $urandom_range(0, 10);
			end
			if (out_hold > 0) begin
				out_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("page_bitmap_allocator: mismatch");
			$finish;
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		if (idx == CFG_KSTART)
			kern_start = val;
		else
			kern_end = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		do @(negedge clk);
		while (op_queue.size() != 0 || in_valid || grants_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic page_op_t blank_op(logic [2:0] k);
		page_op_t op;
		op.kind = k;
		op.base = $urandom;
		op.len = $urandom;
		op.rtype = $urandom;
		op.rstart = $urandom;
		op.rend = $urandom;
		op.faddr = $urandom;
		return op;
	endfunction

	task automatic push_region(logic [31:0] b, logic [31:0] l, logic [31:0] t);
		page_op_t op;
		op = blank_op(KIND_REGION);
		op.base = b;
		op.len = l;
		op.rtype = t;
		op_queue.push_back(op);
	endtask

	task automatic push_reserve(logic [31:0] s, logic [31:0] e);
		page_op_t op;
		op = blank_op(KIND_RESERVE);
		op.rstart = s;
		op.rend = e;
		op_queue.push_back(op);
	endtask

	task automatic push_free(logic [31:0] a);
		page_op_t op;
		op = blank_op(KIND_FREE);
		op.faddr = a;
		op_queue.push_back(op);
	endtask

	initial begin
		int issued;
		int session;
		int avail;
		int nops;
		int pick;
		logic [31:0] s;
		logic [31:0] a;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_KSTART;
		cfg_data <= 32'd0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		fill_all();

		write_reg(CFG_KSTART, 32'h0010_0000);
		write_reg(CFG_KEND, 32'h0010_3800);

		op_queue.push_back(blank_op(KIND_FILL));
		op_queue.push_back(blank_op(KIND_ALLOC));
		push_region(32'h0000_0000, 32'h000A_0000, 32'd1);
		op_queue.push_back(blank_op(KIND_ALLOC));
		push_region(32'hFFFF_F800, 32'h0000_3000, 32'd1);
		push_region(32'h0010_0000, 32'h0030_0000, 32'd2);
		push_region(32'h0010_1234, 32'h0000_5000, 32'd1);
		push_region(32'h07FF_E000, 32'h0000_4000, 32'd1);
		push_reserve(32'h0010_2800, 32'h0010_3001);
		push_reserve(32'hFFFF_F001, 32'hFFFF_FFFF);
		push_reserve(32'h07FF_F000, 32'h0800_2000);
		push_free(32'h0010_4000);
		op_queue.push_back(blank_op(KIND_ALLOC));
		push_free(32'h0010_2000);
		push_free(32'h0000_0000);
		push_free(32'h0010_4001);
		push_free(32'h0800_0000);
		push_free(32'hFFFF_F000);
		op_queue.push_back(blank_op(KIND_FINISH));
		op_queue.push_back(blank_op(KIND_SPARE6));
		op_queue.push_back(blank_op(KIND_SPARE7));
		push_region(32'h0000_0000, 32'hFFFF_FFFF, 32'd1);
		op_queue.push_back(blank_op(KIND_ALLOC));
		push_free(32'h07FF_F000);
		drain();

		issued = 0;
		session = 0;
		while (issued < RANDOM_ITEMS) begin
			drain();
			case (session % 6)
				0: begin
					write_reg(CFG_KSTART, KERNEL_RESET);
					write_reg(CFG_KEND, KERNEL_RESET);
				end
				1: begin
					s = $urandom_range(0, 32'h0030_0000);
					write_reg(CFG_KSTART, s);
					write_reg(CFG_KEND, s + $urandom_range(0, 32'h0002_0000));
				end
				2: begin
					write_reg(CFG_KSTART, 32'h0000_0000);
					write_reg(CFG_KEND, 32'hFFFF_FFFF);
				end
				3: begin
					write_reg(CFG_KSTART, 32'hFFFF_FFFF);
					write_reg(CFG_KEND, 32'h0000_0000);
				end
				4: begin
					write_reg(CFG_KSTART, $urandom | 32'h0800_0000);
					write_reg(CFG_KEND, $urandom);
				end
				default: begin
					write_reg(CFG_KSTART, 32'h07FF_F800);
					write_reg(CFG_KEND, (session == 5) ? 32'h0800_0000 : 32'hFFFF_F000);
				end
			endcase
			if (session == 7) begin
				write_reg(CFG_KSTART, 32'h0000_0000);
				write_reg(CFG_KEND, 32'h0800_0000);
			end
			session++;

			op_queue.push_back(blank_op(KIND_FILL));
			issued++;
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 7) == 0)
					op_queue.push_back(blank_op(KIND_REGION));
				else
					push_region($urandom_range(0, 32'h0040_0000),
						$urandom_range(0, 32'h0004_0000), 32'd1);
				issued++;
			end
			repeat ($urandom_range(0, 2)) begin
				if ($urandom_range(0, 3) == 0)
					s = $urandom;
				else
					s = $urandom_range(0, 32'h0040_0000);
				push_reserve(s, s + $urandom_range(0, 32'h0000_8000));
				issued++;
			end
			if ($urandom_range(0, 3) != 0) begin
				op_queue.push_back(blank_op(KIND_FINISH));
				issued++;
			end
			if ($urandom_range(0, 9) == 0) begin
				op_queue.push_back(blank_op(3'($urandom_range(6, 7))));
				issued++;
			end
			drain();
			granted_pages.delete();
			avail = count_free();

			nops = $urandom_range(40, 80);
			repeat (nops) begin
				pick = $urandom_range(0, 99);
				if ((avail > 0 && pick < 55) || pick == 99) begin
					op_queue.push_back(blank_op(KIND_ALLOC));
					if (avail > 0)
						avail--;
				end else if (granted_pages.size() > 0 && pick < 90) begin
					pick = $urandom_range(0, granted_pages.size() - 1);
					push_free(granted_pages[pick]);
					granted_pages.delete(pick);
					avail++;
				end else begin
					case ($urandom_range(0, 3))
						0: a = $urandom;
						1: a = {20'($urandom_range(0, PAGE_COUNT - 1)), 12'd0};
						2: a = {20'($urandom_range(0, 1023)), 12'd0} |
							32'($urandom_range(0, 1));
						default: a = {20'($urandom_range(0, 1023)), 12'd0};
					endcase
					push_free(a);
				end
				issued++;
				if (op_queue.size() > 8)
					do @(posedge clk); while (op_queue.size() > 2);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("page_bitmap_allocator: match");
		else
			$display("page_bitmap_allocator: mismatch");
		$finish;
	end
endmodule
